FILE: hw/rtl/cde_pkg.sv
// shared constants and types for the circular deque engine
package cde_pkg;

  // ring size and derived widths
  localparam int DEPTH   = 64;
  localparam int WORD_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DIVD_W  = WORD_W - 1;
  localparam int STEP_W  = $clog2(DIVD_W + 1);

  // request operation codes
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_ROTATE = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SHR,
    CMD_SHL,
    CMD_ROT,
    CMD_LOAD
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t           cmd;
    logic [WORD_W-1:0]   word;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/cde_cell.sv
// one storage cell of the deque chain
module cde_cell (
  input  logic                      clk,
  input  cde_pkg::cell_ctl_t        ctl,
  input  logic [cde_pkg::WORD_W-1:0] left_q,
  input  logic [cde_pkg::WORD_W-1:0] right_q,
  input  logic [cde_pkg::WORD_W-1:0] head_q,
  input  logic                      at_last,
  input  logic                      at_free,
  output logic [cde_pkg::WORD_W-1:0] q
);
  import cde_pkg::*;

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;

  // pick the word this cell holds next
  always_comb begin
    data_nxt = data_r;
    unique case (ctl.cmd)
      CMD_HOLD: data_nxt = data_r;
      CMD_SHR:  data_nxt = left_q;
      CMD_SHL:  data_nxt = right_q;
      CMD_ROT:  data_nxt = at_last ? head_q : right_q;
      CMD_LOAD: data_nxt = at_free ? ctl.word : data_r;
      default:  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

FILE: hw/rtl/cde_mod_unit.sv
// bit-serial remainder of the rotation count by the occupancy
module cde_mod_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cde_pkg::DIVD_W-1:0] dividend,
  input  logic [cde_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [cde_pkg::CNT_W-1:0]  remainder
);
  import cde_pkg::*;

  logic [DIVD_W-1:0] quo_r;
  logic [CNT_W-1:0]  div_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  rem_nxt;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    trial;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[DIVD_W-1]};
    rem_nxt = rem_r;
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = CNT_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      // done pulses for one cycle after the last step
      done_r <= busy_r && !start && (step_r == STEP_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DIVD_W);
        quo_r  <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        quo_r  <= {quo_r[DIVD_W-2:0], 1'b0};
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

FILE: hw/rtl/circular_deque_engine.sv
// top level: request sequencer over a chain of storage cells
// A deque of up to 64 signed words kept front-first in a chain of cells (cell 0
// holds the front). Push and pop update the chain and count when taken, unless
// refused as full or empty, and the result is then registered in S_FIN. Rotate
// by a positive k first computes k mod count in a bit-serial remainder unit
// while in S_DIV, then steps the chain one place per cycle in S_ROT. Find walks
// the whole ring once past cell 0, one element per cycle, and leaves the
// contents in place. Requests are handled one at a time; a finished result sits
// in the output register until taken, the sequencer waits while an untaken
// result blocks the next one, and the next request is taken as soon as the
// sequencer is idle.
module circular_deque_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_operation,
  input  logic                        in_at_back,
  input  logic signed [cde_pkg::WORD_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic                        out_found,
  output logic signed [cde_pkg::WORD_W-1:0] out_found_value,
  output logic [cde_pkg::CNT_W-1:0]   out_occupancy
);
  import cde_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ROT,
    S_SCAN,
    S_FIN
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  steps_r;
  logic [WORD_W-1:0] probe_r;
  logic              back_r;
  status_t           res_status_r;
  logic              res_found_r;
  logic [WORD_W-1:0] res_value_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic              out_found_r;
  logic [WORD_W-1:0] out_value_r;
  logic [CNT_W-1:0]  out_occ_r;

  logic              accept;
  logic              is_empty;
  logic              is_full;
  logic              rot_go;
  logic              mod_done;
  logic [CNT_W-1:0]  mod_rem;
  logic              hit;
  cell_ctl_t         ctl;
  logic [WORD_W-1:0] cell_q [DEPTH];
  logic [DEPTH-1:0]  last_vec;
  logic [DEPTH-1:0]  free_vec;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign rot_go   = accept && (op_t'(in_operation) == OP_ROTATE) && !is_empty &&
                    !in_value[WORD_W-1] && (in_value != '0);
  assign hit      = $signed(cell_q[0]) > $signed(probe_r);

  // chain command for this cycle
  always_comb begin
    ctl.cmd  = CMD_HOLD;
    ctl.word = in_value;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(in_operation))
            OP_PUSH: begin
              if (!is_full) begin
                ctl.cmd = (in_at_back || is_empty) ? CMD_LOAD : CMD_SHR;
              end
            end
            OP_POP: begin
              if (!is_empty && !in_at_back) begin
                ctl.cmd = CMD_SHL;
              end
            end
            default: ctl.cmd = CMD_HOLD;
          endcase
        end
      end
      S_ROT, S_SCAN: ctl.cmd = CMD_ROT;
      S_DIV, S_FIN:  ctl.cmd = CMD_HOLD;
      default:       ctl.cmd = CMD_HOLD;
    endcase
  end

  // chain of cells with back and free-slot markers
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [WORD_W-1:0] left_w;
      logic [WORD_W-1:0] right_w;
      assign last_vec[gi] = (count_r == CNT_W'(gi + 1));
      assign free_vec[gi] = (count_r == CNT_W'(gi));
      if (gi == 0) begin : g_first
        assign left_w = ctl.word;
      end else begin : g_mid
        assign left_w = cell_q[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_end
        assign right_w = cell_q[gi];
      end else begin : g_inner
        assign right_w = cell_q[gi+1];
      end
      cde_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .left_q  (left_w),
        .right_q (right_w),
        .head_q  (cell_q[0]),
        .at_last (last_vec[gi]),
        .at_free (free_vec[gi]),
        .q       (cell_q[gi])
      );
    end
  endgenerate

  // rotation count remainder
  cde_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rot_go),
    .dividend  (in_value[DIVD_W-1:0]),
    .divisor   (count_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a taken result clears unless a new one is loaded in the same cycle
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_found_r  <= 1'b0;
            res_value_r  <= '1;
            probe_r      <= in_value;
            back_r       <= in_at_back;
            steps_r      <= count_r;
            case (op_t'(in_operation))
              OP_PUSH: begin
                state_r <= S_FIN;
                if (is_full) begin
                  res_status_r <= ST_FULL;
                end else begin
                  res_status_r <= ST_DONE;
                  count_r      <= count_r + CNT_W'(1);
                end
              end
              OP_POP: begin
                state_r <= S_FIN;
                if (is_empty) begin
                  res_status_r <= ST_EMPTY;
                end else begin
                  res_status_r <= ST_DONE;
                  count_r      <= count_r - CNT_W'(1);
                end
              end
              OP_ROTATE: begin
                state_r      <= rot_go ? S_DIV : S_FIN;
                res_status_r <= is_empty ? ST_EMPTY : ST_DONE;
              end
              default: begin
                state_r      <= is_empty ? S_FIN : S_SCAN;
                res_status_r <= is_empty ? ST_EMPTY : ST_DONE;
              end
            endcase
          end
        end
        S_DIV: begin
          if (mod_done) begin
            steps_r <= mod_rem;
            state_r <= (mod_rem == '0) ? S_FIN : S_ROT;
          end
        end
        S_ROT: begin
          steps_r <= steps_r - CNT_W'(1);
          if (steps_r == CNT_W'(1)) begin
            state_r <= S_FIN;
          end
        end
        S_SCAN: begin
          // from the back, the last hit in front order wins
          if (hit && (back_r || !res_found_r)) begin
            res_found_r <= 1'b1;
            res_value_r <= cell_q[0];
          end
          steps_r <= steps_r - CNT_W'(1);
          if (steps_r == CNT_W'(1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_found_r  <= res_found_r;
            out_value_r  <= res_value_r;
            out_occ_r    <= count_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_found_value = out_value_r;
  assign out_occupancy   = out_occ_r;

endmodule

FILE: dv/circular_deque_engine_test.sv
// self-checking testbench for the circular deque engine: random and directed requests
module circular_deque_engine_test;
  import cde_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned RANDOM_PER_PHASE = 108;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct {
    op_t                      op;
    logic                     at_back;
    logic signed [WORD_W-1:0] value;
  } deque_req_t;

  typedef struct {
    status_t                  status;
    logic                     found;
    logic signed [WORD_W-1:0] found_value;
    logic [CNT_W-1:0]         occupancy;
  } deque_reply_t;

  // traffic mix used to walk the deque between empty and full
  typedef enum {
    TIDE_FILL,
    TIDE_DRAIN,
    TIDE_MIX
  } tide_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  op_t                      in_operation = OP_PUSH;
  logic                     in_at_back = 1'b0;
  logic signed [WORD_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_status;
  logic                     out_found;
  logic signed [WORD_W-1:0] out_found_value;
  logic [CNT_W-1:0]         out_occupancy;

  // model of the deque contents, front first
  logic signed [WORD_W-1:0] deque_words[$];
  deque_req_t               queued_requests[$];
  deque_reply_t             predicted_replies[$];

  logic        req_taken = 1'b0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned gen_count = 0;
  tide_t       tide = TIDE_FILL;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned replies_checked = 0;
  int unsigned ops_taken[4] = '{0, 0, 0, 0};
  int unsigned full_refusals = 0;
  int unsigned empty_refusals = 0;
  int unsigned finds_hit = 0;

  circular_deque_engine i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_at_back      (in_at_back),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_found_value (out_found_value),
    .out_occupancy   (out_occupancy)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // apply one request to the deque model and return the reply it causes
  function automatic deque_reply_t apply_to_deque(deque_req_t req);
    deque_reply_t reply;
    int unsigned  turns;
    int           n;
    int           idx;
    reply.status = ST_DONE;
    reply.found = 1'b0;
    reply.found_value = '1;
    ops_taken[req.op]++;
    case (req.op)
      OP_PUSH: begin
        if (deque_words.size() >= DEPTH) begin
          reply.status = ST_FULL;
        end else if (req.at_back) begin
          deque_words.push_back(req.value);
        end else begin
          deque_words.push_front(req.value);
        end
      end
      OP_POP: begin
        if (deque_words.size() == 0) begin
          reply.status = ST_EMPTY;
        end else if (req.at_back) begin
          void'(deque_words.pop_back());
        end else begin
          void'(deque_words.pop_front());
        end
      end
      OP_ROTATE: begin
        if (deque_words.size() == 0) begin
          reply.status = ST_EMPTY;
        end else if (req.value > 0) begin
          // front elements move to the back in order
          turns = req.value % deque_words.size();
          repeat (turns) deque_words.push_back(deque_words.pop_front());
        end
      end
      default: begin
        if (deque_words.size() == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          // scan from the chosen end for the first strictly greater word
          for (n = 0; n < deque_words.size() && !reply.found; n++) begin
            idx = req.at_back ? deque_words.size() - 1 - n : n;
            if (deque_words[idx] > req.value) begin
              reply.found = 1'b1;
              reply.found_value = deque_words[idx];
            end
          end
        end
      end
    endcase
    reply.occupancy = CNT_W'(deque_words.size());
    if (reply.status == ST_FULL) full_refusals++;
    if (reply.status == ST_EMPTY) empty_refusals++;
    if (reply.found) finds_hit++;
    return reply;
  endfunction

  function automatic void note_mismatch(string what);
    if (mismatches < REPORT_LIMIT) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endfunction

  // queue a request and keep a rough occupancy count for steering the mix
  function automatic void queue_request(op_t op, logic at_back, logic signed [WORD_W-1:0] value);
    queued_requests.push_back('{op, at_back, value});
    if (op == OP_PUSH && gen_count < DEPTH) gen_count++;
    else if (op == OP_POP && gen_count > 0) gen_count--;
  endfunction

  // stored words and probes: extremes, small clustered values, full range
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(16) - 8;
      2: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom_range(2000) - 1000;
    endcase
  endfunction

  // rotation counts: zero, negative, small, huge
  function automatic logic signed [WORD_W-1:0] pick_turns();
    case ($urandom_range(7))
      0: return '0;
      1: return $urandom | 32'h8000_0000;
      2: return $urandom & 32'h7fff_ffff;
      3: return 32'h7fff_ffff;
      default: return $urandom_range(70, 1);
    endcase
  endfunction

  function automatic void queue_random();
    int unsigned roll;
    op_t         op;
    roll = $urandom_range(99);
    case (tide)
      TIDE_FILL:
        op = (roll < 75) ? OP_PUSH : (roll < 80) ? OP_POP : (roll < 90) ? OP_FIND : OP_ROTATE;
      TIDE_DRAIN:
        op = (roll < 70) ? OP_POP : (roll < 75) ? OP_PUSH : (roll < 88) ? OP_FIND : OP_ROTATE;
      default:
        op = (roll < 30) ? OP_PUSH : (roll < 55) ? OP_POP : (roll < 75) ? OP_ROTATE : OP_FIND;
    endcase
    queue_request(op, 1'($urandom_range(1)), (op == OP_ROTATE) ? pick_turns() : pick_word());
    // linger a little at full and empty before turning around
    case (tide)
      TIDE_FILL:
        if (gen_count == DEPTH && $urandom_range(3) == 0)
          tide = $urandom_range(1) ? TIDE_DRAIN : TIDE_MIX;
      TIDE_DRAIN:
        if (gen_count == 0 && $urandom_range(2) == 0)
          tide = $urandom_range(1) ? TIDE_FILL : TIDE_MIX;
      default:
        if ($urandom_range(39) == 0) tide = $urandom_range(1) ? TIDE_FILL : TIDE_DRAIN;
    endcase
  endfunction

  // edge cases: empty refusals, extreme words, find hits and misses, odd rotations
  function automatic void queue_directed();
    queue_request(OP_POP,    1'b0, '0);
    queue_request(OP_POP,    1'b1, '0);
    queue_request(OP_ROTATE, 1'b0, 5);
    queue_request(OP_FIND,   1'b0, 32'h8000_0000);
    queue_request(OP_PUSH,   1'b0, 32'h1234_5678);
    queue_request(OP_FIND,   1'b1, 32'h1234_5678);
    queue_request(OP_POP,    1'b1, '0);
    queue_request(OP_PUSH,   1'b1, 32'h7fff_ffff);
    queue_request(OP_PUSH,   1'b0, 32'h8000_0000);
    queue_request(OP_PUSH,   1'b1, '0);
    queue_request(OP_PUSH,   1'b0, '1);
    queue_request(OP_FIND,   1'b0, 32'h8000_0000);
    queue_request(OP_FIND,   1'b1, 32'h7fff_ffff);
    queue_request(OP_FIND,   1'b1, '1);
    queue_request(OP_FIND,   1'b0, '0);
    queue_request(OP_ROTATE, 1'b0, '0);
    queue_request(OP_ROTATE, 1'b1, 32'h8000_0000);
    queue_request(OP_ROTATE, 1'b0, '1);
    queue_request(OP_ROTATE, 1'b0, 1);
    queue_request(OP_ROTATE, 1'b1, 32'h7fff_ffff);
    queue_request(OP_ROTATE, 1'b0, 4);
    queue_request(OP_PUSH,   1'b1, 32'h5555_5555);
    queue_request(OP_PUSH,   1'b0, 32'haaaa_aaaa);
    queue_request(OP_POP,    1'b1, '0);
    queue_request(OP_POP,    1'b0, '0);
  endfunction

  // request driver and result back-pressure, updated on the falling edge
  always @(negedge clk) begin : drive_requests
    deque_req_t next_req;
    if (rst_n) begin
      if (!in_valid || req_taken) begin
        if (queued_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_req = queued_requests.pop_front();
          in_valid <= 1'b1;
          in_operation <= next_req.op;
          in_at_back <= next_req.at_back;
          in_value <= next_req.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check replies against predictions and predict each accepted request
  always @(posedge clk) begin : check_replies
    deque_reply_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (predicted_replies.size() == 0) begin
          note_mismatch("reply with no request outstanding");
        end else begin
          want = predicted_replies.pop_front();
          replies_checked++;
          if (out_status !== want.status || out_found !== want.found ||
              out_found_value !== want.found_value || out_occupancy !== want.occupancy)
            note_mismatch($sformatf({"status %0d/%0d found %0d/%0d value %0d/%0d ",
                                     "occupancy %0d/%0d (expected/actual)"},
                                    want.status, out_status, want.found, out_found,
                                    want.found_value, out_found_value,
                                    want.occupancy, out_occupancy));
        end
      end
      if (in_valid && in_ready)
        predicted_replies.push_back(apply_to_deque('{in_operation, in_at_back, in_value}));
      req_taken <= in_valid && in_ready;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** circular_deque_engine: FAILED **");
      $finish;
    end
  end

  // phases: no idling, sender idle, receiver stalling, both
  initial begin : run_phases
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    int          ph;
    idle_tab = '{0, 74, 0, 29};
    stall_tab = '{0, 0, 74, 29};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      if (ph == 0) queue_directed();
      repeat (RANDOM_PER_PHASE) queue_random();
      wait (queued_requests.size() == 0);
    end
    wait (!in_valid && predicted_replies.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_replies.size() != 0) note_mismatch("replies still outstanding at end");
    $display("covered %0d replies: push %0d, pop %0d, rotate %0d, find %0d",
             replies_checked, ops_taken[OP_PUSH], ops_taken[OP_POP],
             ops_taken[OP_ROTATE], ops_taken[OP_FIND]);
    $display("full refusals %0d, empty refusals %0d, finds hit %0d, mismatches %0d",
             full_refusals, empty_refusals, finds_hit, mismatches);
    if (mismatches == 0) begin
      $display("** circular_deque_engine: PASSED **");
    end else begin
      $display("** circular_deque_engine: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/cde_pkg.sv
hw/rtl/cde_cell.sv
hw/rtl/cde_mod_unit.sv
hw/rtl/circular_deque_engine.sv
dv/circular_deque_engine_test.sv
